### rtl/mts_pkg.sv
// shared types and constants of the min tracking stack
package mts_pkg;

  localparam int DEPTH = 64;
  localparam int WIDTH = 32;
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam int COUNT_FIELD_W = 7;
  localparam int STATUS_W      = 2;

  typedef logic signed [WIDTH-1:0] word_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [STATUS_W-1:0]     status_t;

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_OVERFLOW  = 2'd1;
  localparam status_t ST_UNDERFLOW = 2'd2;

  // per cycle move of a chain of cells
  typedef struct packed {
    logic push;
    logic pop;
  } shift_ctrl_t;

endpackage

### rtl/mts_if.sv
// channel interfaces of the min tracking stack
interface mts_in_if;
  logic                 valid;
  logic                 ready;
  logic                 mode;
  mts_pkg::word_t       value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

interface mts_out_if;
  logic                                   valid;
  logic                                   ready;
  mts_pkg::word_t                         top_value;
  mts_pkg::word_t                         min_value;
  logic                                   is_empty;
  logic [mts_pkg::COUNT_FIELD_W-1:0]      count;
  mts_pkg::status_t                       status;

  modport source (output valid, output top_value, output min_value, output is_empty,
                  output count, output status, input ready);
  modport sink   (input valid, input top_value, input min_value, input is_empty,
                  input count, input status, output ready);
endinterface

### rtl/mts_cell.sv
// one stack entry: loads from the cell above on push, from the cell below on pop
module mts_cell (
  input  logic                 clk_i,
  input  mts_pkg::shift_ctrl_t ctrl_i,
  input  mts_pkg::word_t       up_i,
  input  mts_pkg::word_t       down_i,
  output mts_pkg::word_t       word_o
);

  mts_pkg::word_t word_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      word_q <= up_i;
    end else if (ctrl_i.pop) begin
      word_q <= down_i;
    end
  end

  assign word_o = word_q;

endmodule

### rtl/mts_chain.sv
// row of cells forming a shift stack, top entry at cell zero
module mts_chain (
  input  logic                 clk_i,
  input  mts_pkg::shift_ctrl_t ctrl_i,
  input  mts_pkg::word_t       push_word_i,
  output mts_pkg::word_t       head0_o,
  output mts_pkg::word_t       head1_o
);

  mts_pkg::word_t words [mts_pkg::DEPTH];

  for (genvar i = 0; i < mts_pkg::DEPTH; i++) begin : g_cell
    mts_pkg::word_t up_w;
    mts_pkg::word_t down_w;

    if (i == 0) begin : g_first
      assign up_w = push_word_i;
    end else begin : g_mid_up
      assign up_w = words[i-1];
    end

    if (i == mts_pkg::DEPTH - 1) begin : g_last
      assign down_w = '0;
    end else begin : g_mid_down
      assign down_w = words[i+1];
    end

    mts_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl_i),
      .up_i   (up_w),
      .down_i (down_w),
      .word_o (words[i])
    );
  end

  assign head0_o = words[0];
  assign head1_o = words[1];

endmodule

### rtl/min_tracking_stack.sv
// top level of the min tracking stack
//
// lifo stack of signed words that also reports its smallest stored value
// in_i carries one word per operation: mode 0 pushes value, mode 1 pops
// out_o returns one word per operation: top, minimum, empty flag, count
// and status (ok, overflow on push to a full stack, underflow on pop of an
// empty one); refused operations leave the stack unchanged
// storage is two rows of cells, a data row and a row of running minima;
// data cells take a neighbor's word in the cycle of a push or pop, min cells
// only on a change of minimum; each top is in cell zero, nothing is ever searched
// latency: the result word is registered, valid the cycle after accept
// throughput: one op per cycle unless stalled, set by the single shift of each row
// reset clears both counts and the output valid; cell contents are left
// as they are and only read where the counts say they were written
// when the receiver stalls the result stays in the output register and
// in_i.ready drops until it is taken; a taken result frees the register
// in the same cycle so a new operation is accepted then
module min_tracking_stack (
  input  logic            clk_i,
  input  logic            rst_ni,
  mts_in_if.sink          in_i,
  mts_out_if.source       out_o
);

  // handshake
  logic in_accept;
  logic out_valid_q;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_accept  = in_i.valid && in_i.ready;

  // stack state
  mts_pkg::cnt_t data_count_q, data_count_d;
  mts_pkg::cnt_t min_count_q,  min_count_d;

  mts_pkg::shift_ctrl_t data_ctrl, min_ctrl;
  mts_pkg::word_t       d0, d1, m0, m1;

  mts_chain u_data_chain (
    .clk_i       (clk_i),
    .ctrl_i      (data_ctrl),
    .push_word_i (in_i.value),
    .head0_o     (d0),
    .head1_o     (d1)
  );

  mts_chain u_min_chain (
    .clk_i       (clk_i),
    .ctrl_i      (min_ctrl),
    .push_word_i (in_i.value),
    .head0_o     (m0),
    .head1_o     (m1)
  );

  // operation decode
  logic is_push, is_pop, full, empty, push_ok, pop_ok, min_push, min_pop;

  assign is_push = in_accept && (in_i.mode == mts_pkg::MODE_PUSH);
  assign is_pop  = in_accept && (in_i.mode == mts_pkg::MODE_POP);
  assign full    = data_count_q >= mts_pkg::CNT_W'(mts_pkg::DEPTH);
  assign empty   = data_count_q == '0;
  assign push_ok = is_push && !full;
  assign pop_ok  = is_pop && !empty;

  // new minimum entry when the min row is empty or the value ties or beats its top
  assign min_push = push_ok && (min_count_q < mts_pkg::CNT_W'(mts_pkg::DEPTH)) &&
                    ((min_count_q == '0) || (in_i.value <= m0));
  // the minimum leaves when the popped word is it
  assign min_pop  = pop_ok && (min_count_q != '0) && (m0 == d0);

  assign data_ctrl = '{push: push_ok,  pop: pop_ok};
  assign min_ctrl  = '{push: min_push, pop: min_pop};

  always_comb begin
    data_count_d = data_count_q;
    min_count_d  = min_count_q;
    if (push_ok) begin
      data_count_d = data_count_q + mts_pkg::CNT_W'(1);
    end else if (pop_ok) begin
      data_count_d = data_count_q - mts_pkg::CNT_W'(1);
    end
    if (min_push) begin
      min_count_d = min_count_q + mts_pkg::CNT_W'(1);
    end else if (min_pop) begin
      min_count_d = min_count_q - mts_pkg::CNT_W'(1);
    end
  end

  // result word, built from the state after the operation
  mts_pkg::word_t   top_d, min_d;
  mts_pkg::status_t status_d;
  logic             has_two, min_has_two;

  assign has_two     = data_count_q > mts_pkg::CNT_W'(1);
  assign min_has_two = min_count_q > mts_pkg::CNT_W'(1);

  always_comb begin
    top_d    = '0;
    min_d    = '0;
    status_d = mts_pkg::ST_OK;
    if (in_i.mode == mts_pkg::MODE_PUSH) begin
      if (full) begin
        status_d = mts_pkg::ST_OVERFLOW;
        top_d    = d0;
        min_d    = (min_count_q != '0) ? m0 : '0;
      end else begin
        top_d = in_i.value;
        if (min_push) begin
          min_d = in_i.value;
        end else if (min_count_q != '0) begin
          min_d = m0;
        end
      end
    end else begin
      if (empty) begin
        status_d = mts_pkg::ST_UNDERFLOW;
      end else if (has_two) begin
        top_d = d1;
        if (min_pop) begin
          min_d = min_has_two ? m1 : '0;
        end else if (min_count_q != '0) begin
          min_d = m0;
        end
      end
    end
  end

  // output register
  mts_pkg::word_t                     top_q, min_q;
  mts_pkg::status_t                   status_q;
  logic [mts_pkg::COUNT_FIELD_W-1:0]  count_q;
  logic                               is_empty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      data_count_q <= '0;
      min_count_q  <= '0;
    end else begin
      data_count_q <= data_count_d;
      min_count_q  <= min_count_d;
      if (in_accept) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      top_q      <= top_d;
      min_q      <= min_d;
      status_q   <= status_d;
      count_q    <= data_count_d[mts_pkg::COUNT_FIELD_W-1:0];
      is_empty_q <= data_count_d == '0;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.top_value = top_q;
  assign out_o.min_value = min_q;
  assign out_o.is_empty  = is_empty_q;
  assign out_o.count     = count_q;
  assign out_o.status    = status_q;

`ifndef SYNTHESIS
  // the min row never holds more entries than the data row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    min_count_q <= data_count_q)
    else $error("min count above data count");

  // a non-empty stack always has a minimum entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (data_count_q != '0) |-> (min_count_q != '0))
    else $error("stack holds words but no minimum");

  // every accepted operation leaves a result waiting in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> out_valid_q)
    else $error("accepted operation lost its result");

  // a refused pop reports an empty stack
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (status_q == mts_pkg::ST_UNDERFLOW)) |-> (is_empty_q && (count_q == '0)))
    else $error("underflow result not empty");
`endif

endmodule

### tb/mts_tb_pkg.sv
// result mirror of the min tracking stack used by the testbench
package mts_tb_pkg;
  import mts_pkg::*;

  typedef struct packed {
    word_t                    top_value;
    word_t                    min_value;
    logic                     is_empty;
    logic [COUNT_FIELD_W-1:0] count;
    status_t                  status;
  } snapshot_t;

  class min_stack_mirror;
    word_t     data_row[DEPTH];
    word_t     min_row[DEPTH];
    int        data_cnt;
    int        min_cnt;
    snapshot_t due_snapshots[$];
    int        mismatches;
    int        checked;
    int        n_push;
    int        n_pop;
    int        n_overflow;
    int        n_underflow;
    int        peak;

    function new();
      data_cnt    = 0;
      min_cnt     = 0;
      mismatches  = 0;
      checked     = 0;
      n_push      = 0;
      n_pop       = 0;
      n_overflow  = 0;
      n_underflow = 0;
      peak        = 0;
    endfunction

    // advance the mirrored stack by one accepted word and queue its snapshot
    function void apply_op(logic op, word_t val);
      snapshot_t s;
      bit        new_min;
      s.status = ST_OK;
      if (op == MODE_PUSH) begin
        n_push++;
        if (data_cnt >= DEPTH) begin
          s.status = ST_OVERFLOW;
          n_overflow++;
        end else begin
          data_row[data_cnt] = val;
          data_cnt++;
          new_min = (min_cnt == 0);
          if (!new_min) new_min = (val <= min_row[min_cnt-1]);
          if (new_min && min_cnt < DEPTH) begin
            min_row[min_cnt] = val;
            min_cnt++;
          end
        end
      end else begin
        n_pop++;
        if (data_cnt == 0) begin
          s.status = ST_UNDERFLOW;
          n_underflow++;
        end else begin
          if (min_cnt > 0 && min_row[min_cnt-1] == data_row[data_cnt-1]) min_cnt--;
          data_cnt--;
        end
      end
      if (data_cnt > peak) peak = data_cnt;
      s.top_value = (data_cnt > 0) ? data_row[data_cnt-1] : word_t'(0);
      s.min_value = (data_cnt > 0 && min_cnt > 0) ? min_row[min_cnt-1] : word_t'(0);
      s.is_empty  = (data_cnt == 0);
      s.count     = COUNT_FIELD_W'(data_cnt);
      due_snapshots.push_back(s);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("result %0d: %s got %h want %h", checked, what, got, want);
      mismatches++;
    endtask

    task compare_snapshot(snapshot_t got);
      snapshot_t want;
      if (due_snapshots.size() == 0) begin
        report_mismatch("word with nothing due, top", got.top_value, 0);
      end else begin
        want = due_snapshots.pop_front();
        if (got.top_value !== want.top_value)
          report_mismatch("top_value", got.top_value, want.top_value);
        if (got.min_value !== want.min_value)
          report_mismatch("min_value", got.min_value, want.min_value);
        if (got.is_empty !== want.is_empty)
          report_mismatch("is_empty", got.is_empty, want.is_empty);
        if (got.count !== want.count)
          report_mismatch("count", got.count, want.count);
        if (got.status !== want.status)
          report_mismatch("status", got.status, want.status);
      end
      checked++;
    endtask
  endclass

endpackage

### tb/tb.sv
// top level testbench of the min tracking stack
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mts_pkg::*;
  import mts_tb_pkg::*;

  // cycles without any accepted word before the run is called hung
  localparam int STALL_LIMIT = 2000;
  // length of the receiver hold-off that backs the stack up
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 90;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #2 clk = ~clk;

  mts_in_if  in_ch ();
  mts_out_if out_ch ();

  min_tracking_stack dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  min_stack_mirror mirror = new();

  // idling knobs, changed by the stimulus process between phases
  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  // receiver hold-off request, counted down by the receiver itself
  int hold_len = 0;
  int quiet_cycles = 0;

  // everything the block sees is known from time zero
  initial begin
    in_ch.valid   = 1'b0;
    in_ch.mode    = MODE_PUSH;
    in_ch.value   = '0;
    out_ch.ready  = 1'b0;
  end

  // receiver: ready changes on the falling edge only
  initial begin
    forever begin
      @(negedge clk);
      if (hold_len > 0) begin
        out_ch.ready <= 1'b0;
        hold_len--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  // result words are taken and checked at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      mirror.compare_snapshot('{out_ch.top_value, out_ch.min_value, out_ch.is_empty,
                                out_ch.count, out_ch.status});
  end

  // watchdog: any accepted word on either side restarts the count
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
        $display("Mismatches found");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // offer one word, with random sender gaps, and note it once accepted
  task automatic send_op(input logic op, input word_t val);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode  <= op;
    in_ch.value <= val;
    do @(posedge clk); while (!in_ch.ready);
    mirror.apply_op(op, val);
  endtask

  // values lean on the extremes and on a narrow band so that equal minima
  // and ties with the current minimum come up often
  function automatic word_t pick_value();
    case ($urandom_range(9))
      0:       return word_t'(32'h8000_0000);
      1:       return word_t'(32'h7fff_ffff);
      2:       return word_t'(0);
      3:       return word_t'(-1);
      4, 5, 6: return word_t'(int'($urandom_range(16)) - 8);
      default: return word_t'($urandom());
    endcase
  endfunction

  // runs of balanced, push heavy, pop heavy traffic, or a fill to the top
  // with a few refused pushes past it
  task automatic run_segment(input int kind, input int len, inout int left);
    int push_pct;
    int extra;
    case (kind)
      0:       push_pct = 50;
      1:       push_pct = 85;
      2:       push_pct = 15;
      default: push_pct = 100;
    endcase
    if (kind == 3) begin
      extra = $urandom_range(1, 3);
      len = DEPTH - mirror.data_cnt + extra;
    end
    repeat (len) begin
      if ($urandom_range(99) < push_pct) send_op(MODE_PUSH, pick_value());
      else send_op(MODE_POP, word_t'($urandom()));
      left--;
    end
  endtask

  task automatic run_random(input int n);
    int left;
    left = n;
    while (left > 0) run_segment($urandom_range(3), $urandom_range(10, 40), left);
  endtask

  initial begin
    int left;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: underflow on empty, extremes, duplicate minima, pops that
    // do and do not remove the minimum, back to empty and under again
    send_op(MODE_POP,  word_t'(32'h1234_5678));
    send_op(MODE_PUSH, word_t'(32'h7fff_ffff));
    send_op(MODE_PUSH, word_t'(32'h8000_0000));
    send_op(MODE_PUSH, word_t'(32'h8000_0000));
    send_op(MODE_PUSH, word_t'(0));
    send_op(MODE_PUSH, word_t'(-1));
    send_op(MODE_PUSH, word_t'(32'h7fff_ffff));
    send_op(MODE_POP,  word_t'(0));
    send_op(MODE_POP,  word_t'(0));
    send_op(MODE_POP,  word_t'(0));
    send_op(MODE_POP,  word_t'(-1));
    send_op(MODE_POP,  word_t'(-1));
    send_op(MODE_POP,  word_t'(0));
    send_op(MODE_POP,  word_t'(0));
    send_op(MODE_PUSH, word_t'(5));
    send_op(MODE_PUSH, word_t'(5));
    send_op(MODE_PUSH, word_t'(6));
    send_op(MODE_PUSH, word_t'(5));
    send_op(MODE_POP,  word_t'(0));
    send_op(MODE_POP,  word_t'(0));
    send_op(MODE_POP,  word_t'(0));
    send_op(MODE_POP,  word_t'(0));
    send_op(MODE_PUSH, word_t'(32'haaaa_aaaa));
    send_op(MODE_PUSH, word_t'(32'h5555_5555));

    // random phases with different idling on each side
    src_idle_pct = 0;  snk_stall_pct = 0;  run_random(PHASE_ITEMS);
    src_idle_pct = 85; snk_stall_pct = 0;  run_random(PHASE_ITEMS);
    src_idle_pct = 0;  snk_stall_pct = 85; run_random(PHASE_ITEMS);
    src_idle_pct = 27; snk_stall_pct = 27; run_random(PHASE_ITEMS);

    // back pressure: receiver holds off while the sender keeps filling
    src_idle_pct = 0; snk_stall_pct = 0;
    hold_len = HOLD_CYCLES;
    left = 0;
    run_segment(3, 0, left);
    run_random(30);

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (mirror.due_snapshots.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("checked %0d result words: %0d pushes (%0d overflow), %0d pops (%0d underflow)",
             mirror.checked, mirror.n_push, mirror.n_overflow, mirror.n_pop,
             mirror.n_underflow);
    $display("peak depth %0d of %0d; idle mixes none, sender, receiver, both, and a hold-off",
             mirror.peak, DEPTH);
    if (mirror.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
